@@ hw/rtl/kmet_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmet_pkg
// Shared types, constants and helpers for the key matrix edge tracker.
// ----------------------------------------------------------------------------
package kmet_pkg;

  // per-key flags, bit0 down, bit1 pressed, bit2 released
  typedef struct packed {
    logic released;
    logic pressed;
    logic down;
  } key_flag_t;

  // summary of one scanned column
  typedef struct packed {
    logic       any_down;
    logic [4:0] pop;
    logic [6:0] first;
  } col_sum_t;

  localparam logic [6:0] CodeNone = 7'h7F;
  localparam logic [5:0] CountMax = 6'd63;
  localparam int unsigned LevelW  = 6;

  // next flags of one key from its old flags and its sampled level
  function automatic key_flag_t scan_key(key_flag_t old, logic is_down);
    key_flag_t nf;
    nf.down     = is_down;
    nf.pressed  = is_down & ~old.down;
    nf.released = ~is_down & old.down;
    return nf;
  endfunction

endpackage

@@ hw/rtl/kmet_col_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmet_col_update
// Updates the flags of one matrix column and summarizes its down keys.
// ----------------------------------------------------------------------------
module kmet_col_update import kmet_pkg::*; #(
  parameter int unsigned NUM_ROWS = 6
) (
  input  logic      [2:0]          col_i,
  input  logic      [LevelW-1:0]   levels_i,
  input  key_flag_t [NUM_ROWS-1:0] old_i,
  output key_flag_t [NUM_ROWS-1:0] new_o,
  output col_sum_t                 sum_o
);

  logic [NUM_ROWS-1:0] down;
  logic [4:0]          pop;
  logic [4:0]          first_row;
  logic [7:0]          base;
  logic [7:0]          code;

  // row levels, rows beyond the pin field read as down
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (r < LevelW) begin
        down[r] = ~levels_i[r];
      end else begin
        down[r] = 1'b1;
      end
    end
  end

  // flag update per row
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      new_o[r] = scan_key(old_i[r], down[r]);
    end
  end

  // population count and lowest down row
  always_comb begin
    pop       = '0;
    first_row = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      pop = pop + 5'(down[r]);
    end
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (down[r]) begin
        first_row = 5'(r);
      end
    end
  end

  // key code of the first down key in this column
  assign base = 8'(col_i) * 8'(NUM_ROWS);
  assign code = base + 8'(first_row);

  assign sum_o.any_down = |down;
  assign sum_o.pop      = pop;
  assign sum_o.first    = code[6:0];

endmodule

@@ hw/rtl/key_matrix_edge_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_edge_tracker_unit
// Tracks down/pressed/released flags of a scanned key matrix plus an ON key,
// counts down keys per frame and reports the first down key at frame end.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o    | column_index, row_levels, on_level,
//          |                            | frame_last
//  out     | out_valid_o / out_stall_i  | column_echo, down/pressed/released
//          |                            | bits, on_flags, keys_down, first_key,
//          |                            | first_changed, frame_done
//
//  One item per cycle sustained while the output is not stalled; results
//  pass through stage one and the output register. Row flags sit in a
//  column-wide memory read at acceptance and written back from stage one;
//  a same-column item right behind is forwarded. Reset clears the
//  per-column valid bits, so no clearing pass is needed. A stalled output
//  register holds the pipeline; in_stall_o rises once stage one is also full.
// ----------------------------------------------------------------------------
module key_matrix_edge_tracker_unit import kmet_pkg::*; #(
  parameter int unsigned NUM_COLUMNS = 7,
  parameter int unsigned NUM_ROWS    = 6,
  parameter int unsigned ON_KEY_CODE = 42
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         column_index_i,
  input  logic [5:0]         row_levels_i,
  input  logic               on_level_i,
  input  logic               frame_last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         column_echo_o,
  output logic [5:0]         down_bits_o,
  output logic [5:0]         pressed_bits_o,
  output logic [5:0]         released_bits_o,
  output logic [2:0]         on_flags_o,
  output logic [5:0]         keys_down_o,
  output logic signed [6:0]  first_key_o,
  output logic               first_changed_o,
  output logic               frame_done_o
);

  localparam int unsigned AW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int unsigned CW = AW + 3;
  localparam logic [6:0]  OnCode = 7'(ON_KEY_CODE % 128);

  typedef key_flag_t [NUM_ROWS-1:0] row_t;

  // flag memory, one word per column
  row_t                   mem_q [NUM_COLUMNS];
  row_t                   rd_data_q;
  logic [NUM_COLUMNS-1:0] col_vld_q;

  // stage one
  logic                   s1_vld_q;
  logic [2:0]             s1_col_q;
  logic [5:0]             s1_lvl_q;
  logic                   s1_on_q;
  logic                   s1_last_q;
  logic                   byp_hit_q;
  row_t                   byp_data_q;

  // frame state
  key_flag_t              on_q;
  logic [5:0]             cnt_q;
  logic [6:0]             first_q;
  logic [6:0]             prev_q;

  logic [CW-1:0]          in_ext;
  logic [CW-1:0]          s1_ext;
  logic [AW-1:0]          in_addr;
  logic [AW-1:0]          s1_addr;
  logic                   in_rng;
  logic                   s1_rng;
  logic                   in_acc;
  logic                   s1_go;
  row_t                   old_row;
  row_t                   new_row;
  col_sum_t               col_sum;
  logic [6:0]             cnt_sum;
  logic [5:0]             cnt1;
  logic [6:0]             first1;
  key_flag_t              on_new;
  logic                   on_down;
  logic [5:0]             cnt2;
  logic [6:0]             first2;
  logic                   changed;
  logic [5:0]             dn_bits;
  logic [5:0]             pr_bits;
  logic [5:0]             rl_bits;

  // handshake
  assign s1_go      = ~out_valid_o | ~out_stall_i;
  assign in_stall_o = s1_vld_q & ~s1_go;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // column addressing
  assign in_ext  = CW'(column_index_i);
  assign s1_ext  = CW'(s1_col_q);
  assign in_addr = in_ext[AW-1:0];
  assign s1_addr = s1_ext[AW-1:0];
  assign in_rng  = in_ext < CW'(NUM_COLUMNS);
  assign s1_rng  = s1_ext < CW'(NUM_COLUMNS);

  // memory read at acceptance, write back from stage one
  always_ff @(posedge clk_i) begin
    if (in_acc && in_rng) begin
      rd_data_q <= mem_q[in_addr];
    end
    if (s1_vld_q && s1_go && s1_rng) begin
      mem_q[s1_addr] <= new_row;
    end
  end

  // per-column valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_vld_q <= '0;
    end else if (s1_vld_q && s1_go && s1_rng) begin
      col_vld_q[s1_addr] <= 1'b1;
    end
  end

  // stage one control, loads whenever stage one is empty or draining
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      byp_hit_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_vld_q  <= in_acc;
      byp_hit_q <= in_acc & s1_vld_q & s1_rng & (s1_col_q == column_index_i);
    end
  end

  // stage one payload and forwarded row
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q   <= column_index_i;
      s1_lvl_q   <= row_levels_i;
      s1_on_q    <= on_level_i;
      s1_last_q  <= frame_last_i;
      byp_data_q <= new_row;
    end
  end

  // old flags: forwarded, stored, or reset value
  always_comb begin
    if (byp_hit_q) begin
      old_row = byp_data_q;
    end else if (col_vld_q[s1_addr]) begin
      old_row = rd_data_q;
    end else begin
      old_row = '0;
    end
  end

  kmet_col_update #(
    .NUM_ROWS (NUM_ROWS)
  ) u_col_update (
    .col_i    (s1_col_q),
    .levels_i (s1_lvl_q),
    .old_i    (old_row),
    .new_o    (new_row),
    .sum_o    (col_sum)
  );

  // running count and first key after this column
  always_comb begin
    cnt_sum = 7'(cnt_q) + (s1_rng ? 7'(col_sum.pop) : 7'd0);
    cnt1    = (cnt_sum > 7'(CountMax)) ? CountMax : cnt_sum[5:0];
    if (s1_rng && col_sum.any_down && (col_sum.first < first_q)) begin
      first1 = col_sum.first;
    end else begin
      first1 = first_q;
    end
  end

  // ON key and frame totals
  always_comb begin
    on_down = ~s1_on_q;
    on_new  = scan_key(on_q, on_down);
    cnt2    = (on_down && (cnt1 < CountMax)) ? cnt1 + 6'd1 : cnt1;
    first2  = (on_down && (first1 == CodeNone)) ? OnCode : first1;
    changed = (first2 != CodeNone) && (first2 != prev_q);
  end

  // frame state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q    <= '0;
      cnt_q   <= '0;
      first_q <= CodeNone;
      prev_q  <= CodeNone;
    end else if (s1_vld_q && s1_go) begin
      if (s1_last_q) begin
        on_q    <= on_new;
        cnt_q   <= '0;
        first_q <= CodeNone;
        prev_q  <= first2;
      end else begin
        cnt_q   <= cnt1;
        first_q <= first1;
      end
    end
  end

  // row flags onto the fixed-width output fields
  always_comb begin
    dn_bits = '0;
    pr_bits = '0;
    rl_bits = '0;
    for (int r = 0; r < LevelW; r++) begin
      if (s1_rng && (r < NUM_ROWS)) begin
        dn_bits[r] = new_row[r].down;
        pr_bits[r] = new_row[r].pressed;
        rl_bits[r] = new_row[r].released;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_go) begin
      out_valid_o <= s1_vld_q;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (s1_go && s1_vld_q) begin
      column_echo_o   <= s1_col_q;
      down_bits_o     <= dn_bits;
      pressed_bits_o  <= pr_bits;
      released_bits_o <= rl_bits;
      frame_done_o    <= s1_last_q;
      if (s1_last_q) begin
        on_flags_o      <= on_new;
        keys_down_o     <= cnt2;
        first_key_o     <= first2;
        first_changed_o <= changed;
      end else begin
        on_flags_o      <= '0;
        keys_down_o     <= '0;
        first_key_o     <= '0;
        first_changed_o <= 1'b0;
      end
    end
  end

endmodule
